// File: design/word_memory_with_mmio_timer_uart_macros.svh
`ifndef WORD_MEMORY_WITH_MMIO_TIMER_UART_MACROS_SVH
`define WORD_MEMORY_WITH_MMIO_TIMER_UART_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define WMT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("port assertion failed");

// Implication whose consequent is checked after the antecedent, outside reset.
`define WMT_ASSERT_IMP2(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##2 (cons)) \
        else $error("port assertion failed");

// Consequent checked against a past value of the antecedent, outside reset.
`define WMT_ASSERT_PAST2(lbl, cons, ante) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cons) |-> $past((ante), 2)) \
        else $error("port assertion failed");

`endif

// File: design/wmt_pkg.sv
`timescale 1ns / 1ps

package wmt_pkg;

    localparam int MEM_WORDS = 16384;
    localparam int IDX_W     = $clog2(MEM_WORDS);
    localparam int Q_DEPTH   = 2;
    localparam int PTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [31:0] MEM_BASE   = 32'h8000_0000;
    localparam logic [31:0] TIMER_LO   = 32'ha000_0048;
    localparam logic [31:0] TIMER_HI   = 32'ha000_005c;
    localparam logic [31:0] SERIAL_OUT = 32'ha000_03f8;

    localparam logic [1:0] REQ_READ   = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] SZ_ZERO = 2'd0;
    localparam logic [1:0] SZ_BYTE = 2'd1;
    localparam logic [1:0] SZ_HALF = 2'd2;
    localparam logic [1:0] SZ_WORD = 2'd3;

    typedef enum logic [2:0] {
        OP_NOP     = 3'd0,
        OP_RD_MEM  = 3'd1,
        OP_RD_TLO  = 3'd2,
        OP_RD_THI  = 3'd3,
        OP_WR_MEM  = 3'd4,
        OP_WR_UART = 3'd5,
        OP_TICK    = 3'd6
    } t_op;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] addr;
        logic [31:0] write_data;
        logic [1:0]  store_size;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic        uart_valid;
        logic [7:0]  uart_byte;
    } t_rsp;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
        logic [3:0]       byte_en;
        logic [31:0]      wdata;
        logic [7:0]       uart_byte;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

endpackage

// File: design/word_memory_with_mmio_timer_uart.sv
`timescale 1ns / 1ps

// Data memory of 16384 words at 0x80000000 with a 64-bit microsecond timer
// (low half at 0xa0000048, high half at 0xa000005c) and a serial output at
// 0xa00003f8. One transaction is taken per clock; it is written into the
// command queue and then registered by the back end; its result appears on
// o_rsp with o_done high for one cycle, and must be captured then since the
// receiver cannot stall the block. The
// command queue drains one entry per cycle through the single memory port,
// so busy never rises. Reading a word never written returns an undefined
// value.
module word_memory_with_mmio_timer_uart (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  wmt_pkg::t_req i_req,
    output logic          o_done,
    output wmt_pkg::t_rsp o_rsp
);

    logic           full;
    logic           pop;
    wmt_pkg::t_push push;
    wmt_pkg::t_head head;

    wmt_front u_front (
        .start  (start),
        .i_full (full),
        .i_req  (i_req),
        .busy   (busy),
        .o_push (push)
    );

    wmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    wmt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

endmodule

// File: design/wmt_front.sv
`timescale 1ns / 1ps

module wmt_front (
    input  logic          start,
    input  logic          i_full,
    input  wmt_pkg::t_req i_req,
    output logic          busy,
    output wmt_pkg::t_push o_push
);

    logic [31:0] off;
    logic [1:0]  lane;

    assign busy = i_full;
    assign off  = i_req.addr - wmt_pkg::MEM_BASE;
    assign lane = i_req.addr[1:0];

    always_comb begin
        o_push.push          = start && !i_full;
        o_push.cmd.op        = wmt_pkg::OP_NOP;
        o_push.cmd.idx       = off[wmt_pkg::IDX_W+1:2];
        o_push.cmd.byte_en   = 4'b1111;
        o_push.cmd.wdata     = '0;
        o_push.cmd.uart_byte = '0;

        unique case (i_req.store_size)
            wmt_pkg::SZ_BYTE: begin
                o_push.cmd.byte_en = 4'b0001 << lane;
                o_push.cmd.wdata   = {4{i_req.write_data[7:0]}};
            end
            wmt_pkg::SZ_HALF: begin
                o_push.cmd.byte_en = (lane == 2'd0) ? 4'b0011 : 4'b1100;
                o_push.cmd.wdata   = {2{i_req.write_data[15:0]}};
            end
            wmt_pkg::SZ_WORD: begin
                o_push.cmd.wdata = i_req.write_data;
            end
            default: begin
                o_push.cmd.wdata = '0;
            end
        endcase

        unique case (i_req.req_type)
            wmt_pkg::REQ_READ: begin
                if (i_req.addr == wmt_pkg::TIMER_LO) begin
                    o_push.cmd.op = wmt_pkg::OP_RD_TLO;
                end else if (i_req.addr == wmt_pkg::TIMER_HI) begin
                    o_push.cmd.op = wmt_pkg::OP_RD_THI;
                end else begin
                    o_push.cmd.op = wmt_pkg::OP_RD_MEM;
                end
            end
            wmt_pkg::REQ_WRITE: begin
                if (i_req.addr == wmt_pkg::SERIAL_OUT) begin
                    o_push.cmd.op        = wmt_pkg::OP_WR_UART;
                    o_push.cmd.uart_byte = o_push.cmd.wdata[7:0];
                end else begin
                    o_push.cmd.op = wmt_pkg::OP_WR_MEM;
                end
            end
            wmt_pkg::REQ_TICK: begin
                o_push.cmd.op = wmt_pkg::OP_TICK;
            end
            default: begin
                o_push.cmd.op = wmt_pkg::OP_NOP;
            end
        endcase
    end

endmodule

// File: design/wmt_queue.sv
`timescale 1ns / 1ps

module wmt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wmt_pkg::t_push i_push,
    input  logic           i_pop,
    output logic           o_full,
    output wmt_pkg::t_head o_head
);

    wmt_pkg::t_cmd                r_buf [wmt_pkg::Q_DEPTH];
    logic [wmt_pkg::PTR_W-1:0]    r_wptr;
    logic [wmt_pkg::PTR_W-1:0]    r_rptr;
    logic [wmt_pkg::CNT_W-1:0]    r_count;
    logic [wmt_pkg::PTR_W-1:0]    n_wptr;
    logic [wmt_pkg::PTR_W-1:0]    n_rptr;
    logic [wmt_pkg::CNT_W-1:0]    n_count;
    logic                         do_push;
    logic                         do_pop;

    assign o_full       = (r_count == wmt_pkg::CNT_W'(wmt_pkg::Q_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_buf[r_rptr];
    assign do_push      = i_push.push && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == wmt_pkg::PTR_W'(wmt_pkg::Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == wmt_pkg::PTR_W'(wmt_pkg::Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wptr] <= i_push.cmd;
        end
    end

endmodule

// File: design/wmt_back.sv
`timescale 1ns / 1ps

module wmt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wmt_pkg::t_head i_head,
    output logic           o_pop,
    output logic           o_done,
    output wmt_pkg::t_rsp  o_rsp
);

    logic [31:0] r_mem [wmt_pkg::MEM_WORDS];
    logic [31:0] r_mem_q;
    logic [63:0] r_usec;
    logic [63:0] n_usec;
    logic        r_done;
    logic        r_from_mem;
    logic [31:0] r_aux;
    logic        r_uv;
    logic [7:0]  r_ub;
    wmt_pkg::t_op op;

    assign o_pop = i_head.valid;
    assign op    = i_head.cmd.op;

    always_comb begin
        n_usec = r_usec;
        if (i_head.valid && op == wmt_pkg::OP_TICK) begin
            n_usec = r_usec + 64'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_usec <= '0;
            r_done <= 1'b0;
        end else begin
            r_usec <= n_usec;
            r_done <= i_head.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_head.valid) begin
            r_from_mem <= (op == wmt_pkg::OP_RD_MEM);
            r_uv       <= (op == wmt_pkg::OP_WR_UART);
            r_ub       <= (op == wmt_pkg::OP_WR_UART) ? i_head.cmd.uart_byte : 8'd0;
            r_aux      <= (op == wmt_pkg::OP_RD_TLO) ? r_usec[31:0]  :
                          (op == wmt_pkg::OP_RD_THI) ? r_usec[63:32] : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_head.valid && op == wmt_pkg::OP_WR_MEM) begin
            for (int l = 0; l < 4; l++) begin
                if (i_head.cmd.byte_en[l]) begin
                    r_mem[i_head.cmd.idx][8*l +: 8] <= i_head.cmd.wdata[8*l +: 8];
                end
            end
        end
        if (i_head.valid && op == wmt_pkg::OP_RD_MEM) begin
            r_mem_q <= r_mem[i_head.cmd.idx];
        end
    end

    assign o_done               = r_done;
    assign o_rsp.read_data      = !r_done ? 32'd0 : (r_from_mem ? r_mem_q : r_aux);
    assign o_rsp.uart_valid     = r_done && r_uv;
    assign o_rsp.uart_byte      = r_done ? r_ub : 8'd0;

endmodule

// File: design/wmt_checker.sv
`timescale 1ns / 1ps
`include "word_memory_with_mmio_timer_uart_macros.svh"

module wmt_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input wmt_pkg::t_req i_req,
    input logic          o_done,
    input wmt_pkg::t_rsp o_rsp
);

    logic serial_acc;

    assign serial_acc = start && !busy && i_req.req_type == wmt_pkg::REQ_WRITE &&
                        i_req.addr == wmt_pkg::SERIAL_OUT;

    `WMT_ASSERT_IMP2(a_result_follows, start && !busy, o_done)
    `WMT_ASSERT_PAST2(a_result_has_cause, o_done, start && !busy)
    `WMT_ASSERT_IMP2(a_serial_emits, serial_acc, o_rsp.uart_valid)
    `WMT_ASSERT_IMP(a_uart_quiet, !o_rsp.uart_valid, o_rsp.uart_byte == 8'd0)

endmodule

bind word_memory_with_mmio_timer_uart wmt_checker u_wmt_checker (.*);

// File: tb/sv/word_memory_with_mmio_timer_uart_tb.sv
`timescale 1ns / 1ps

module word_memory_with_mmio_timer_uart_tb;

    localparam int RANDOM_ITEMS = 1000;
    localparam int HOT_WORDS    = 48;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 10;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic cmd_start = 1'b0;
    wmt_pkg::t_req cmd_req = '0;
    logic busy;
    logic o_done;
    wmt_pkg::t_rsp o_rsp;

    wmt_pkg::t_req req_pend_q[$];
    wmt_pkg::t_rsp rsp_due_q[$];
    int unsigned   full_word_q[$];
    logic [3:0]    gen_lanes[wmt_pkg::MEM_WORDS];
    int unsigned   hot_words[HOT_WORDS];

    logic [31:0] mem_image[wmt_pkg::MEM_WORDS];
    logic [63:0] usec_ticks = '0;

    int n_items   = 0;
    int n_taken   = 0;
    int err_cnt   = 0;
    int idle_cyc  = 0;
    int burst_left = 1;
    int gap_left   = 0;

    word_memory_with_mmio_timer_uart u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (cmd_start),
        .busy    (busy),
        .i_req   (cmd_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned word_of(logic [31:0] a);
        logic [31:0] off;
        off = (a & ~32'h3) - wmt_pkg::MEM_BASE;
        return int'(off[wmt_pkg::IDX_W+1:2]);
    endfunction

    function automatic logic [31:0] merge_lanes(logic [31:0] old, wmt_pkg::t_req rq);
        logic [31:0] nw;
        nw = old;
        case (rq.store_size)
            wmt_pkg::SZ_BYTE: nw[8*rq.addr[1:0] +: 8] = rq.write_data[7:0];
            wmt_pkg::SZ_HALF: begin
                if (rq.addr[1:0] == 2'd0) nw[15:0] = rq.write_data[15:0];
                else nw[31:16] = rq.write_data[15:0];
            end
            wmt_pkg::SZ_WORD: nw = rq.write_data;
            default: nw = '0;
        endcase
        return nw;
    endfunction

    function automatic wmt_pkg::t_rsp predict_response(wmt_pkg::t_req rq);
        wmt_pkg::t_rsp rs;
        int unsigned   ix;
        logic [31:0]   nw;
        rs = '0;
        ix = word_of(rq.addr);
        case (rq.req_type)
            wmt_pkg::REQ_READ: begin
                if (rq.addr == wmt_pkg::TIMER_LO) rs.read_data = usec_ticks[31:0];
                else if (rq.addr == wmt_pkg::TIMER_HI) rs.read_data = usec_ticks[63:32];
                else rs.read_data = mem_image[ix];
            end
            wmt_pkg::REQ_WRITE: begin
                nw = merge_lanes(mem_image[ix], rq);
                if (rq.addr == wmt_pkg::SERIAL_OUT) begin
                    rs.uart_valid = 1'b1;
                    rs.uart_byte  = nw[7:0];
                end else begin
                    mem_image[ix] = nw;
                end
            end
            wmt_pkg::REQ_TICK: usec_ticks = usec_ticks + 64'd1;
            default: ;
        endcase
        return rs;
    endfunction

    task automatic add_item(logic [1:0] rt, logic [31:0] a, logic [31:0] wd, logic [1:0] sz);
        wmt_pkg::t_req rq;
        int unsigned   ix;
        logic [3:0]    lanes;
        rq = '{req_type: rt, addr: a, write_data: wd, store_size: sz};
        req_pend_q.push_back(rq);
        n_items++;
        if (rt == wmt_pkg::REQ_WRITE && a != wmt_pkg::SERIAL_OUT) begin
            ix = word_of(a);
            case (sz)
                wmt_pkg::SZ_BYTE: lanes = 4'b0001 << a[1:0];
                wmt_pkg::SZ_HALF: lanes = (a[1:0] == 2'd0) ? 4'b0011 : 4'b1100;
                default: lanes = 4'hf;
            endcase
            if (gen_lanes[ix] != 4'hf && (gen_lanes[ix] | lanes) == 4'hf)
                full_word_q.push_back(ix);
            gen_lanes[ix] = gen_lanes[ix] | lanes;
        end
    endtask

    function automatic logic [31:0] compose_addr(int unsigned ix);
        logic [15:0] hi;
        hi = ($urandom_range(0, 4) == 0) ? 16'($urandom) : wmt_pkg::MEM_BASE[31:16];
        return {hi, wmt_pkg::IDX_W'(ix), 2'($urandom)};
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
        err_cnt++;
    endtask

    initial begin
        int          pick;
        int unsigned ix;
        logic [31:0] a;
        foreach (gen_lanes[i]) gen_lanes[i] = 4'h0;
        foreach (mem_image[i]) mem_image[i] = '0;
        foreach (hot_words[i]) hot_words[i] = $urandom_range(0, wmt_pkg::MEM_WORDS - 1);
        hot_words[0] = 0;
        hot_words[1] = wmt_pkg::MEM_WORDS - 1;

        add_item(wmt_pkg::REQ_WRITE, 32'h8000_0000, 32'hffff_ffff, wmt_pkg::SZ_WORD);
        add_item(wmt_pkg::REQ_READ,  32'h8000_0000, 32'h0, wmt_pkg::SZ_ZERO);
        add_item(wmt_pkg::REQ_WRITE, 32'h8000_0004, 32'hdead_beef, wmt_pkg::SZ_ZERO);
        add_item(wmt_pkg::REQ_READ,  32'h8000_0006, 32'h0, wmt_pkg::SZ_BYTE);
        add_item(wmt_pkg::REQ_WRITE, 32'h8000_0004, 32'habcd_ef11, wmt_pkg::SZ_BYTE);
        add_item(wmt_pkg::REQ_WRITE, 32'h8000_0005, 32'h1234_5622, wmt_pkg::SZ_BYTE);
        add_item(wmt_pkg::REQ_WRITE, 32'h8000_0006, 32'hfedc_ba33, wmt_pkg::SZ_BYTE);
        add_item(wmt_pkg::REQ_WRITE, 32'h8000_0007, 32'h0000_00c4, wmt_pkg::SZ_BYTE);
        add_item(wmt_pkg::REQ_READ,  32'h8000_0004, 32'hffff_ffff, wmt_pkg::SZ_WORD);
        add_item(wmt_pkg::REQ_WRITE, 32'h8000_0008, 32'h0123_4567, wmt_pkg::SZ_WORD);
        add_item(wmt_pkg::REQ_WRITE, 32'h8000_0008, 32'hffff_a5a5, wmt_pkg::SZ_HALF);
        add_item(wmt_pkg::REQ_WRITE, 32'h8000_000b, 32'h0000_5a5a, wmt_pkg::SZ_HALF);
        add_item(wmt_pkg::REQ_READ,  32'h8000_0009, 32'h0, wmt_pkg::SZ_HALF);
        add_item(wmt_pkg::REQ_WRITE, 32'h8000_0009, 32'h7777_beef, wmt_pkg::SZ_HALF);
        add_item(wmt_pkg::REQ_READ,  32'h8000_0008, 32'h0, wmt_pkg::SZ_ZERO);
        add_item(wmt_pkg::REQ_WRITE, 32'h8000_fffc, 32'h8000_0001, wmt_pkg::SZ_WORD);
        add_item(wmt_pkg::REQ_READ,  32'h0000_fffc, 32'h0, wmt_pkg::SZ_WORD);
        add_item(wmt_pkg::REQ_READ,  32'hffff_ffff, 32'h0, wmt_pkg::SZ_WORD);
        add_item(wmt_pkg::REQ_TICK,  32'h0, 32'h0, wmt_pkg::SZ_ZERO);
        add_item(wmt_pkg::REQ_TICK,  32'hffff_ffff, 32'hffff_ffff, wmt_pkg::SZ_WORD);
        add_item(wmt_pkg::REQ_READ,  wmt_pkg::TIMER_LO, 32'h0, wmt_pkg::SZ_ZERO);
        add_item(wmt_pkg::REQ_READ,  wmt_pkg::TIMER_HI, 32'h0, wmt_pkg::SZ_ZERO);
        add_item(wmt_pkg::REQ_WRITE, wmt_pkg::SERIAL_OUT, 32'hffff_ffa5, wmt_pkg::SZ_ZERO);
        add_item(wmt_pkg::REQ_WRITE, wmt_pkg::SERIAL_OUT, 32'hffff_ffa5, wmt_pkg::SZ_BYTE);
        add_item(wmt_pkg::REQ_WRITE, wmt_pkg::SERIAL_OUT, 32'h0000_00ff, wmt_pkg::SZ_HALF);
        add_item(wmt_pkg::REQ_WRITE, wmt_pkg::SERIAL_OUT, 32'h1234_5641, wmt_pkg::SZ_WORD);
        add_item(wmt_pkg::REQ_UNUSED, 32'h8000_0000, 32'hffff_ffff, wmt_pkg::SZ_WORD);

        repeat (RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                ix = ($urandom_range(0, 3) == 0)
                         ? $urandom_range(0, wmt_pkg::MEM_WORDS - 1)
                         : hot_words[$urandom_range(0, HOT_WORDS - 1)];
                a = ($urandom_range(0, 9) == 0) ? $urandom : compose_addr(ix);
                add_item(wmt_pkg::REQ_WRITE, a, $urandom, 2'($urandom));
            end else if (pick < 75) begin
                if (full_word_q.size() == 0 || $urandom_range(0, 9) == 0)
                    add_item(wmt_pkg::REQ_READ,
                             $urandom_range(0, 1) ? wmt_pkg::TIMER_LO : wmt_pkg::TIMER_HI,
                             $urandom, 2'($urandom));
                else
                    add_item(wmt_pkg::REQ_READ,
                             compose_addr(full_word_q[$urandom_range(0, full_word_q.size() - 1)]),
                             $urandom, 2'($urandom));
            end else if (pick < 88) begin
                add_item(wmt_pkg::REQ_TICK, $urandom, $urandom, 2'($urandom));
            end else if (pick < 94) begin
                add_item(wmt_pkg::REQ_WRITE, wmt_pkg::SERIAL_OUT, $urandom, 2'($urandom));
            end else begin
                add_item(wmt_pkg::REQ_UNUSED, $urandom, $urandom, 2'($urandom));
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_taken < n_items) @(posedge i_clk);
        while (rsp_due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    always @(posedge i_clk) begin : drv
        if (!i_rst_n) begin
            cmd_start <= 1'b0;
        end else begin
            if (cmd_start && !busy) begin
                rsp_due_q.push_back(predict_response(cmd_req));
                n_taken++;
            end
            // hold the transaction while the block is busy
            if (!(cmd_start && busy)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    cmd_start <= 1'b0;
                end else if (req_pend_q.size() != 0) begin
                    cmd_start <= 1'b1;
                    cmd_req   <= req_pend_q.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                                 : $urandom_range(0, 4);
                    end
                end else begin
                    cmd_start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : mon
        wmt_pkg::t_rsp want;
        if (i_rst_n && o_done) begin
            if (rsp_due_q.size() == 0) begin
                flag_mismatch("unexpected transaction", o_rsp.read_data, 32'h0);
            end else begin
                want = rsp_due_q.pop_front();
                if (o_rsp.read_data !== want.read_data)
                    flag_mismatch("read_data", o_rsp.read_data, want.read_data);
                if (o_rsp.uart_valid !== want.uart_valid)
                    flag_mismatch("uart_valid", 32'(o_rsp.uart_valid), 32'(want.uart_valid));
                if (o_rsp.uart_byte !== want.uart_byte)
                    flag_mismatch("uart_byte", 32'(o_rsp.uart_byte), 32'(want.uart_byte));
            end
        end
    end

    always @(posedge i_clk) begin : wdog
        if ((cmd_start && !busy) || o_done) begin
            idle_cyc = 0;
        end else begin
            idle_cyc++;
            if (idle_cyc >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule
